>>> design/acp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acp_pkg - shared types and constants of the escape sequence parser
// Item structs, display command codes, character codes and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package acp_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic [7:0] cur_row;
        logic [7:0] cur_col;
    } rx_item_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] glyph;
        logic [7:0] new_row;
        logic [7:0] new_col;
        logic [2:0] fore_colour;
        logic [2:0] back_colour;
        logic       bold_on;
    } disp_item_t;

    // Display command codes.
    localparam logic [2:0] ACT_PUT       = 3'd0;
    localparam logic [2:0] ACT_MOVE      = 3'd1;
    localparam logic [2:0] ACT_ERASE_SCR = 3'd2;
    localparam logic [2:0] ACT_ERASE_EOL = 3'd3;
    localparam logic [2:0] ACT_ATTR      = 3'd4;
    localparam logic [2:0] ACT_STATUS    = 3'd5;

    // Configuration register indexes and reset values.
    localparam int         CFG_IDX_W      = 1;
    localparam logic [0:0] CFG_LAST_ROW   = 1'b0;
    localparam logic [0:0] CFG_LAST_COL   = 1'b1;
    localparam logic [7:0] LAST_ROW_RESET = 8'd23;
    localparam logic [7:0] LAST_COL_RESET = 8'd79;

    // Character codes.
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_XON       = 8'h11;
    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_LAST_CTRL = 8'd31;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_LBRACK    = 8'h5B;

    // Final bytes of control sequences.
    localparam logic [7:0] FIN_UP      = 8'h41;
    localparam logic [7:0] FIN_DOWN    = 8'h42;
    localparam logic [7:0] FIN_FWD     = 8'h43;
    localparam logic [7:0] FIN_BACK    = 8'h44;
    localparam logic [7:0] FIN_POS     = 8'h48;
    localparam logic [7:0] FIN_POS_ALT = 8'h66;
    localparam logic [7:0] FIN_ED      = 8'h4A;
    localparam logic [7:0] FIN_EL      = 8'h4B;
    localparam logic [7:0] FIN_SGR     = 8'h6D;
    localparam logic [7:0] FIN_DSR     = 8'h6E;

    // Parameter values.
    localparam logic [15:0] PARAM_MAX   = 16'hFFFF;
    localparam logic [15:0] ED_ALL      = 16'd2;
    localparam logic [15:0] EL_TO_END   = 16'd0;
    localparam logic [15:0] EL_TO_START = 16'd1;
    localparam logic [15:0] EL_LINE     = 16'd2;
    localparam logic [15:0] DSR_CURSOR  = 16'd6;
    localparam logic [15:0] SGR_RESET   = 16'd0;
    localparam logic [15:0] SGR_BOLD    = 16'd1;
    localparam logic [15:0] SGR_SWAP    = 16'd7;
    localparam logic [15:0] SGR_FG_LO   = 16'd30;
    localparam logic [15:0] SGR_FG_HI   = 16'd37;
    localparam logic [15:0] SGR_BG_LO   = 16'd40;
    localparam logic [15:0] SGR_BG_HI   = 16'd47;
    localparam logic [2:0]  FG_DEFAULT  = 3'd7;
    localparam logic [2:0]  BG_DEFAULT  = 3'd0;

    typedef enum logic [4:0] {
        ST_NORMAL = 5'b00001,
        ST_ESC    = 5'b00010,
        ST_CSI    = 5'b00100,
        ST_WALK   = 5'b01000,
        ST_EMIT   = 5'b10000
    } ctrl_state_t;

    // Classification of the offered byte, and walk progress.
    typedef struct packed {
        logic esc;
        logic lbrack;
        logic digit;
        logic semi;
        logic sgr;
        logic fin_res;
        logic txt_res;
        logic walk_last;
    } dp_status_t;

    typedef struct packed {
        logic clr_params;
        logic fold;
        logic advance;
        logic walk_start;
        logic walk_step;
        logic load_txt;
        logic load_fin;
        logic load_sgr;
    } dp_cmd_t;

endpackage
`default_nettype wire

>>> design/acp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acp_ctrl - parser controller
// Tracks the parse mode, sequences the attribute walk and owns the valid
// flag of the output register.
// ----------------------------------------------------------------------------
module acp_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rx_valid,
    output logic                    rx_stall,
    output logic                    disp_valid,
    input  wire logic               disp_stall,
    input  wire acp_pkg::dp_status_t status,
    output acp_pkg::dp_cmd_t        cmd
);

    acp_pkg::ctrl_state_t state_reg;
    acp_pkg::ctrl_state_t state_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_free;
    logic                 can_take;
    logic                 needs_out;
    logic                 take_ok;
    logic                 acc;

    assign out_free = !out_valid_reg || !disp_stall;

    always_comb
    begin
        can_take  = 1'b0;
        needs_out = 1'b0;
        unique case (state_reg)
            acp_pkg::ST_NORMAL:
            begin
                can_take  = 1'b1;
                needs_out = status.txt_res;
            end
            acp_pkg::ST_ESC:
            begin
                can_take = 1'b1;
            end
            acp_pkg::ST_CSI:
            begin
                can_take  = 1'b1;
                needs_out = status.fin_res;
            end
            default:
            begin
                can_take = 1'b0;
            end
        endcase
    end

    // Outside the attribute walk and emit states, a byte that yields no command is taken even while a result waits.
    assign take_ok  = can_take && (!needs_out || out_free);
    assign rx_stall = !take_ok;
    assign acc      = rx_valid && take_ok;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            acp_pkg::ST_NORMAL:
            begin
                if (acc)
                begin
                    cmd.load_txt = status.txt_res;
                    if (status.esc)
                    begin
                        state_next = acp_pkg::ST_ESC;
                    end
                end
            end
            acp_pkg::ST_ESC:
            begin
                if (acc)
                begin
                    if (status.lbrack)
                    begin
                        cmd.clr_params = 1'b1;
                        state_next     = acp_pkg::ST_CSI;
                    end
                    else
                    begin
                        state_next = acp_pkg::ST_NORMAL;
                    end
                end
            end
            acp_pkg::ST_CSI:
            begin
                if (acc)
                begin
                    if (status.digit)
                    begin
                        cmd.fold = 1'b1;
                    end
                    else if (status.semi)
                    begin
                        cmd.advance = 1'b1;
                    end
                    else if (status.sgr)
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = acp_pkg::ST_WALK;
                    end
                    else
                    begin
                        cmd.load_fin = status.fin_res;
                        state_next   = acp_pkg::ST_NORMAL;
                    end
                end
            end
            acp_pkg::ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_last)
                begin
                    state_next = acp_pkg::ST_EMIT;
                end
            end
            acp_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.load_sgr = 1'b1;
                    state_next   = acp_pkg::ST_NORMAL;
                end
            end
            default:
            begin
                state_next = acp_pkg::ST_NORMAL;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_txt || cmd.load_fin || cmd.load_sgr)
        begin
            out_valid_next = 1'b1;
        end
        else if (!disp_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= acp_pkg::ST_NORMAL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign disp_valid = out_valid_reg;

endmodule
`default_nettype wire

>>> design/acp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acp_dp - parser datapath
// Holds the screen limits, the parameter slots, the attribute registers and
// the output register, and works out the command for each final byte.
// ----------------------------------------------------------------------------
module acp_dp #(
    parameter int PARAM_SLOTS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [acp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    input  wire acp_pkg::rx_item_t             rx_item,
    input  wire acp_pkg::dp_cmd_t              cmd,
    output acp_pkg::dp_status_t                status,
    output acp_pkg::disp_item_t                disp_item
);

    localparam int IDX_W = $clog2(PARAM_SLOTS);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(PARAM_SLOTS - 1);

    logic [7:0]          last_row_reg;
    logic [7:0]          last_col_reg;
    logic [15:0]         params_reg [PARAM_SLOTS];
    logic [IDX_W-1:0]    pidx_reg;
    logic [IDX_W-1:0]    walk_idx_reg;
    logic [2:0]          fg_reg;
    logic [2:0]          bg_reg;
    logic                bold_reg;
    acp_pkg::disp_item_t out_reg;
    acp_pkg::disp_item_t out_next;

    logic [7:0]  ch;
    logic [16:0] row17;
    logic [16:0] col17;
    logic [16:0] n17;
    logic [15:0] p0;
    logic [15:0] p1;
    logic [IDX_W-1:0] rd_addr;
    logic [15:0] rd_param;
    logic [19:0] fold_sum;
    logic [15:0] folded;
    logic [7:0]  up_row;
    logic [7:0]  down_row;
    logic [7:0]  fwd_col;
    logic [7:0]  back_col;
    logic [7:0]  abs_row;
    logic [7:0]  abs_col;
    logic        fin_res;
    logic [2:0]  fin_action;
    logic [7:0]  fin_row;
    logic [7:0]  fin_col;
    logic [15:0] fg_off;
    logic [15:0] bg_off;
    logic [2:0]  fg_next;
    logic [2:0]  bg_next;
    logic        bold_next;

    function automatic logic [7:0] clamp_hi(input logic [16:0] v, input logic [7:0] hi);
        logic [7:0] r;
        if (v > {9'd0, hi})
        begin
            r = hi;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

    assign ch    = rx_item.rx_byte;
    assign row17 = {9'd0, rx_item.cur_row};
    assign col17 = {9'd0, rx_item.cur_col};
    assign p0    = params_reg[0];
    assign p1    = params_reg[1];
    assign n17   = (p0 == 16'd0) ? 17'd1 : {1'b0, p0};

    // One read port serves both digit folding and the attribute walk.
    assign rd_addr  = cmd.walk_step ? walk_idx_reg : pidx_reg;
    assign rd_param = params_reg[rd_addr];
    assign fold_sum = ({4'd0, rd_param} << 3) + ({4'd0, rd_param} << 1) + {16'd0, ch[3:0]};
    assign folded   = (fold_sum > {4'd0, acp_pkg::PARAM_MAX}) ? acp_pkg::PARAM_MAX
                                                               : fold_sum[15:0];

    assign up_row   = (n17 > row17) ? 8'd0 : clamp_hi(row17 - n17, last_row_reg);
    assign down_row = clamp_hi(row17 + n17, last_row_reg);
    assign fwd_col  = clamp_hi(col17 + n17, last_col_reg);
    assign back_col = (n17 > col17) ? 8'd0 : clamp_hi(col17 - n17, last_col_reg);
    assign abs_row  = (p0 == 16'd0) ? 8'd0 : clamp_hi({1'b0, p0} - 17'd1, last_row_reg);
    assign abs_col  = (p1 == 16'd0) ? 8'd0 : clamp_hi({1'b0, p1} - 17'd1, last_col_reg);

    always_comb
    begin
        fin_res    = 1'b0;
        fin_action = acp_pkg::ACT_MOVE;
        fin_row    = 8'd0;
        fin_col    = 8'd0;
        unique case (ch)
            acp_pkg::FIN_UP:
            begin
                fin_res = 1'b1;
                fin_row = up_row;
                fin_col = rx_item.cur_col;
            end
            acp_pkg::FIN_DOWN:
            begin
                fin_res = 1'b1;
                fin_row = down_row;
                fin_col = rx_item.cur_col;
            end
            acp_pkg::FIN_FWD:
            begin
                fin_res = 1'b1;
                fin_row = rx_item.cur_row;
                fin_col = fwd_col;
            end
            acp_pkg::FIN_BACK:
            begin
                fin_res = 1'b1;
                fin_row = rx_item.cur_row;
                fin_col = back_col;
            end
            acp_pkg::FIN_POS, acp_pkg::FIN_POS_ALT:
            begin
                fin_res = 1'b1;
                fin_row = abs_row;
                fin_col = abs_col;
            end
            acp_pkg::FIN_ED:
            begin
                fin_res    = (p0 == acp_pkg::ED_ALL);
                fin_action = acp_pkg::ACT_ERASE_SCR;
            end
            acp_pkg::FIN_EL:
            begin
                fin_action = acp_pkg::ACT_ERASE_EOL;
                fin_row    = rx_item.cur_row;
                if (p0 == acp_pkg::EL_TO_END)
                begin
                    fin_res = 1'b1;
                    fin_col = rx_item.cur_col;
                end
                else if (p0 == acp_pkg::EL_TO_START || p0 == acp_pkg::EL_LINE)
                begin
                    fin_res = 1'b1;
                end
            end
            acp_pkg::FIN_DSR:
            begin
                fin_res    = (p0 == acp_pkg::DSR_CURSOR);
                fin_action = acp_pkg::ACT_STATUS;
            end
            default:
            begin
                fin_res = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        status.esc       = (ch == acp_pkg::CH_ESC);
        status.lbrack    = (ch == acp_pkg::CH_LBRACK);
        status.digit     = (ch >= acp_pkg::CH_ZERO) && (ch <= acp_pkg::CH_NINE);
        status.semi      = (ch == acp_pkg::CH_SEMI);
        status.sgr       = (ch == acp_pkg::FIN_SGR);
        status.fin_res   = fin_res;
        status.txt_res   = (ch > acp_pkg::CH_LAST_CTRL) || (ch == acp_pkg::CH_BS) ||
                           (ch == acp_pkg::CH_LF) || (ch == acp_pkg::CH_XON);
        status.walk_last = (walk_idx_reg == pidx_reg);
    end

    // One attribute parameter is applied per walk cycle.
    assign fg_off = rd_param - acp_pkg::SGR_FG_LO;
    assign bg_off = rd_param - acp_pkg::SGR_BG_LO;

    always_comb
    begin
        fg_next   = fg_reg;
        bg_next   = bg_reg;
        bold_next = bold_reg;
        if (rd_param == acp_pkg::SGR_RESET)
        begin
            fg_next   = acp_pkg::FG_DEFAULT;
            bg_next   = acp_pkg::BG_DEFAULT;
            bold_next = 1'b0;
        end
        else if (rd_param == acp_pkg::SGR_BOLD)
        begin
            bold_next = 1'b1;
        end
        else if (rd_param == acp_pkg::SGR_SWAP)
        begin
            fg_next = bg_reg;
            bg_next = fg_reg;
        end
        else if (rd_param >= acp_pkg::SGR_FG_LO && rd_param <= acp_pkg::SGR_FG_HI)
        begin
            fg_next = fg_off[2:0];
        end
        else if (rd_param >= acp_pkg::SGR_BG_LO && rd_param <= acp_pkg::SGR_BG_HI)
        begin
            bg_next = bg_off[2:0];
        end
    end

    always_comb
    begin
        out_next             = out_reg;
        out_next.fore_colour = fg_reg;
        out_next.back_colour = bg_reg;
        out_next.bold_on     = bold_reg;
        out_next.glyph       = 8'd0;
        out_next.new_row     = 8'd0;
        out_next.new_col     = 8'd0;
        if (cmd.load_txt)
        begin
            out_next.action = acp_pkg::ACT_PUT;
            out_next.glyph  = (ch == acp_pkg::CH_XON) ? acp_pkg::CH_SPACE : ch;
        end
        else if (cmd.load_fin)
        begin
            out_next.action  = fin_action;
            out_next.new_row = fin_row;
            out_next.new_col = fin_col;
        end
        else
        begin
            out_next.action = acp_pkg::ACT_ATTR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_row_reg <= acp_pkg::LAST_ROW_RESET;
            last_col_reg <= acp_pkg::LAST_COL_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == acp_pkg::CFG_LAST_ROW)
            begin
                last_row_reg <= cfg_data;
            end
            if (cfg_index == acp_pkg::CFG_LAST_COL)
            begin
                last_col_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PARAM_SLOTS; i++)
            begin
                params_reg[i] <= 16'd0;
            end
            pidx_reg <= '0;
        end
        else if (cmd.clr_params)
        begin
            for (int i = 0; i < PARAM_SLOTS; i++)
            begin
                params_reg[i] <= 16'd0;
            end
            pidx_reg <= '0;
        end
        else if (cmd.fold)
        begin
            params_reg[pidx_reg] <= folded;
        end
        else if (cmd.advance && pidx_reg != LAST_SLOT)
        begin
            pidx_reg <= pidx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_idx_reg <= '0;
            fg_reg       <= acp_pkg::FG_DEFAULT;
            bg_reg       <= acp_pkg::BG_DEFAULT;
            bold_reg     <= 1'b0;
        end
        else if (cmd.walk_start)
        begin
            walk_idx_reg <= '0;
        end
        else if (cmd.walk_step)
        begin
            walk_idx_reg <= walk_idx_reg + 1'b1;
            fg_reg       <= fg_next;
            bg_reg       <= bg_next;
            bold_reg     <= bold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_txt || cmd.load_fin || cmd.load_sgr)
        begin
            out_reg <= out_next;
        end
    end

    assign disp_item = out_reg;

endmodule
`default_nettype wire

>>> design/ansi_csi_terminal_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ansi_csi_terminal_parser_core - ANSI/VT100 escape sequence parser
// Turns a received text stream into display commands, one byte per item.
// ----------------------------------------------------------------------------
// A byte that yields a command waits while the output register still holds an
// untaken command; other bytes are not held back by it. After the attribute
// final 'm' no byte is taken until the attribute unit has applied the collected
// parameters (1 to PARAM_SLOTS), one per cycle, and loaded the output register
// once it is free. Screen limits are to be written by the user through the
// configuration port at index 0 (bottom row) and 1 (rightmost column) only
// while the parser is idle; the block itself does not enforce this.
module ansi_csi_terminal_parser_core #(
    parameter int PARAM_SLOTS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [acp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    input  wire logic                          rx_valid,
    output logic                               rx_stall,
    input  wire acp_pkg::rx_item_t             rx_item,
    output logic                               disp_valid,
    input  wire logic                          disp_stall,
    output acp_pkg::disp_item_t                disp_item
);

    acp_pkg::dp_status_t status;
    acp_pkg::dp_cmd_t    cmd;

    acp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .disp_valid (disp_valid),
        .disp_stall (disp_stall),
        .status     (status),
        .cmd        (cmd)
    );

    acp_dp #(
        .PARAM_SLOTS (PARAM_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_item   (rx_item),
        .cmd       (cmd),
        .status    (status),
        .disp_item (disp_item)
    );

endmodule
`default_nettype wire

>>> design/acp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acp_checker - port level checks of the escape sequence parser
// Watches the receive and display command channels and tracks the attribute state.
// ----------------------------------------------------------------------------
module acp_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                rx_valid,
    input wire logic                rx_stall,
    input wire acp_pkg::rx_item_t   rx_item,
    input wire logic                disp_valid,
    input wire logic                disp_stall,
    input wire acp_pkg::disp_item_t disp_item
);

    logic [2:0] seen_fg_reg;
    logic [2:0] seen_bg_reg;
    logic       seen_bold_reg;
    logic       rx_take;

    assign rx_take = rx_valid && !rx_stall && (rx_item.rx_byte == acp_pkg::CH_ESC);

    // Attributes last delivered; only an attribute item may change them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_fg_reg   <= acp_pkg::FG_DEFAULT;
            seen_bg_reg   <= acp_pkg::BG_DEFAULT;
            seen_bold_reg <= 1'b0;
        end
        else if (disp_valid && !disp_stall)
        begin
            seen_fg_reg   <= disp_item.fore_colour;
            seen_bg_reg   <= disp_item.back_colour;
            seen_bold_reg <= disp_item.bold_on;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid && disp_stall |=> disp_valid && $stable(disp_item))
        else $error("display item changed while stalled");

    a_attr_only: assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid && disp_item.action != acp_pkg::ACT_ATTR |->
            disp_item.fore_colour == seen_fg_reg &&
            disp_item.back_colour == seen_bg_reg &&
            disp_item.bold_on == seen_bold_reg)
        else $error("attributes changed without an attribute item");

    a_put_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid && disp_item.action == acp_pkg::ACT_PUT |->
            (disp_item.glyph > acp_pkg::CH_LAST_CTRL || disp_item.glyph == acp_pkg::CH_BS ||
             disp_item.glyph == acp_pkg::CH_LF) &&
            disp_item.new_row == 8'd0 && disp_item.new_col == 8'd0)
        else $error("control byte drawn or position set on a put item");

    a_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid && (disp_item.action == acp_pkg::ACT_ERASE_SCR ||
                       disp_item.action == acp_pkg::ACT_ATTR ||
                       disp_item.action == acp_pkg::ACT_STATUS) |->
            disp_item.glyph == 8'd0 && disp_item.new_row == 8'd0 &&
            disp_item.new_col == 8'd0)
        else $error("stray glyph or position on a command item");

    a_esc_silent: assert property (@(posedge clk) disable iff (!rst_n)
        rx_take && !disp_valid |=> !disp_valid)
        else $error("escape byte produced a display item");

endmodule

bind ansi_csi_terminal_parser_core acp_checker u_acp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_item    (rx_item),
    .disp_valid (disp_valid),
    .disp_stall (disp_stall),
    .disp_item  (disp_item)
);
`default_nettype wire
